@@ hw/rtl/cgct_pkg.sv @@
// ----------------------------------------------------------------------------
// cgct_pkg: shared types and constants of the gray census transform
// Configuration layout, queue entry flags, queue status and back-end states.
// ----------------------------------------------------------------------------
package cgct_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_FRAME_WIDTH       = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT      = 2'd1;
   localparam logic [1:0] CSR_CONTRAST_GAIN     = 2'd2;
   localparam logic [1:0] CSR_BRIGHTNESS_OFFSET = 2'd3;

   localparam logic [10:0] FRAME_WIDTH_RESET       = 11'd450;
   localparam logic [10:0] FRAME_HEIGHT_RESET      = 11'd300;
   localparam logic [10:0] CONTRAST_GAIN_RESET     = 11'd77;
   localparam logic [8:0]  BRIGHTNESS_OFFSET_RESET = 9'd50;

   localparam int MAX_HEIGHT = 1024;
   localparam int ROW_W      = 10;

   // Gray weights in units of 1/2^14.
   localparam logic [13:0] GRAY_W0    = 14'd4899;
   localparam logic [13:0] GRAY_W1    = 14'd9617;
   localparam logic [13:0] GRAY_W2    = 14'd1868;
   localparam logic [13:0] GRAY_ROUND = 14'd8192;

   localparam int QUEUE_DEPTH = 4;

   // Result slots of one pixel, in the order they leave the block.
   localparam logic [1:0] SLOT_ABOVE_LEFT  = 2'd0;
   localparam logic [1:0] SLOT_ABOVE_RIGHT = 2'd1;
   localparam logic [1:0] SLOT_LAST_LEFT   = 2'd2;
   localparam logic [1:0] SLOT_LAST_RIGHT  = 2'd3;

   typedef struct packed {
      logic [10:0]        frame_width;
      logic [10:0]        frame_height;
      logic [10:0]        contrast_gain;
      logic signed [8:0]  brightness_offset;
   } cfg_type;

   typedef struct packed {
      logic x_first;
      logic x_last;
      logic y_ge1;
      logic y_ge2;
      logic y_last;
   } flags_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_FETCH,
      BK_UPDATE,
      BK_EMIT
   } back_state_type;

endpackage

@@ hw/rtl/cgct_front.sv @@
// ----------------------------------------------------------------------------
// cgct_front: pixel intake, contrast adjust, gray conversion, classification
// Three-stage pipeline that turns a pixel into a gray value with its position
// flags and pushes it into the queue.
// ----------------------------------------------------------------------------
module cgct_front #(
   parameter int MAX_WIDTH      = 1024,
   parameter int GAIN_FRAC_BITS = 8,
   localparam int CW            = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  cgct_pkg::cfg_type   cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic                queue_full,
   output logic                push,
   output logic [7:0]          push_gray,
   output logic [CW-1:0]       push_x,
   output cgct_pkg::flags_type push_flags
);

   localparam int EW     = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int PROD_W = 20;
   localparam int WP_W   = 22;
   localparam logic [PROD_W-1:0] GAIN_ROUND = PROD_W'(2 ** (GAIN_FRAC_BITS - 1));

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic                           s3_valid_ff, s3_valid_in;
   logic [2:0][PROD_W-1:0]         s1_prod_ff, s1_prod_in;
   logic [2:0][WP_W-1:0]           s2_wprod_ff, s2_wprod_in;
   logic [7:0]                     s3_gray_ff, s3_gray_in;
   logic [CW-1:0]                  s1_x_ff, s2_x_ff, s3_x_ff;
   cgct_pkg::flags_type            s1_flags_ff, s2_flags_ff, s3_flags_ff;
   logic [CW-1:0]                  col_ff, col_in;
   logic [cgct_pkg::ROW_W-1:0]     row_ff, row_in;

   logic                           advance, accept;
   logic [EW-1:0]                  fw_ext, w_eff;
   logic [10:0]                    h_eff;
   logic [CW-1:0]                  x;
   logic [cgct_pkg::ROW_W-1:0]     y;
   cgct_pkg::flags_type            flags;
   logic [2:0][7:0]                adj;
   logic [WP_W:0]                  gray_sum;

   // Fraction drop, offset and clamp of one channel after the rounded gain product.
   function automatic logic [7:0] clamp_channel(input logic [PROD_W-1:0] prod,
                                                input logic signed [8:0] offset);
      logic signed [PROD_W+1:0] v;
      v = $signed({2'b00, prod >> GAIN_FRAC_BITS}) + (PROD_W + 2)'(offset);
      if (v < 0) begin
         return 8'd0;
      end else if (v > (PROD_W + 2)'(255)) begin
         return 8'd255;
      end
      return v[7:0];
   endfunction

   assign advance    = !s3_valid_ff || !queue_full;
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;
   assign push       = s3_valid_ff && !queue_full;
   assign push_gray  = s3_gray_ff;
   assign push_x     = s3_x_ff;
   assign push_flags = s3_flags_ff;

   // Position of the incoming pixel, with the frame size brought into range.
   always_comb begin
      fw_ext = EW'(cfg.frame_width);
      if (fw_ext == '0) begin
         w_eff = EW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (cfg.frame_height == '0) begin
         h_eff = 11'd1;
      end else if (cfg.frame_height > 11'(cgct_pkg::MAX_HEIGHT)) begin
         h_eff = 11'(cgct_pkg::MAX_HEIGHT);
      end else begin
         h_eff = cfg.frame_height;
      end
      x = (EW'(col_ff) < w_eff) ? col_ff : CW'(w_eff - EW'(1));
      y = (11'(row_ff) < h_eff) ? row_ff : cgct_pkg::ROW_W'(h_eff - 11'd1);
      flags.x_first = (x == '0);
      flags.x_last  = (EW'(x) == w_eff - EW'(1));
      flags.y_ge1   = (y != '0);
      flags.y_ge2   = (y > cgct_pkg::ROW_W'(1));
      flags.y_last  = (11'(y) == h_eff - 11'd1);
      if (flags.x_last) begin
         col_in = '0;
         row_in = flags.y_last ? '0 : y + cgct_pkg::ROW_W'(1);
      end else begin
         col_in = x + CW'(1);
         row_in = y;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_prod_in[k] = PROD_W'(cfg.contrast_gain) * PROD_W'(req_tdata[8*k +: 8])
                         + GAIN_ROUND;
         adj[k]        = clamp_channel(s1_prod_ff[k], cfg.brightness_offset);
      end
      s2_wprod_in[0] = WP_W'(cgct_pkg::GRAY_W0) * WP_W'(adj[0]);
      s2_wprod_in[1] = WP_W'(cgct_pkg::GRAY_W1) * WP_W'(adj[1]);
      s2_wprod_in[2] = WP_W'(cgct_pkg::GRAY_W2) * WP_W'(adj[2]);
      gray_sum = (WP_W + 1)'(s2_wprod_ff[0]) + (WP_W + 1)'(s2_wprod_ff[1])
                 + (WP_W + 1)'(s2_wprod_ff[2]) + (WP_W + 1)'(cgct_pkg::GRAY_ROUND);
      s3_gray_in = 8'(gray_sum >> 14);
      s1_valid_in = accept;
      s2_valid_in = s1_valid_ff;
      s3_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
            s3_valid_ff <= s3_valid_in;
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= s1_prod_in;
         s1_x_ff     <= x;
         s1_flags_ff <= flags;
         s2_wprod_ff <= s2_wprod_in;
         s2_x_ff     <= s1_x_ff;
         s2_flags_ff <= s1_flags_ff;
         s3_gray_ff  <= s3_gray_in;
         s3_x_ff     <= s2_x_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

endmodule

@@ hw/rtl/cgct_fifo.sv @@
// ----------------------------------------------------------------------------
// cgct_fifo: short queue between the front and the back
// Register-based first-in first-out store with full and empty status.
// ----------------------------------------------------------------------------
module cgct_fifo #(
   parameter int DATA_W = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [DATA_W-1:0]        push_data,
   input  logic                     pop,
   output logic [DATA_W-1:0]        pop_data,
   output cgct_pkg::queue_status_type status
);

   localparam int DEPTH = cgct_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      count_in  = count_ff + NW'(push) - NW'(pop);
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == NW'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/cgct_back.sv @@
// ----------------------------------------------------------------------------
// cgct_back: line stores, 3x3 window and census code output
// Sequencer that reads the line stores, shifts the window and sends the
// codes that each pixel completes through an output register.
// ----------------------------------------------------------------------------
module cgct_back #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW       = $clog2(MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cgct_pkg::queue_status_type queue_status,
   output logic                       pop,
   input  logic [7:0]                 head_gray,
   input  logic [CW-1:0]              head_x,
   input  cgct_pkg::flags_type        head_flags,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [8:0]                 rsp_code,
   output logic                       rsp_last
);

   typedef logic [8:0][7:0] window_type;

   cgct_pkg::back_state_type state_ff, state_in;

   logic [7:0]          older_mem [MAX_WIDTH];
   logic [7:0]          newer_mem [MAX_WIDTH];
   logic [7:0]          older_rd_ff, newer_rd_ff;
   logic [7:0]          cur_gray_ff;
   logic [CW-1:0]       cur_x_ff;
   cgct_pkg::flags_type cur_flags_ff;
   window_type          win_ff, win_in;
   logic [3:0]          pend_ff, pend_in, new_mask, pend_left;
   logic                rsp_valid_ff;
   logic [8:0]          rsp_code_ff;
   logic                rsp_last_ff;

   logic                mem_wr, win_load, emit, out_free;
   logic [1:0]          sel;
   logic [7:0]          top, mid;

   // Code of the window moved down by row_off and right by col_off; places
   // past the stored window are outside the frame and read as zero.
   function automatic logic [8:0] census_of(input window_type win,
                                            input logic row_off,
                                            input logic col_off);
      logic [8:0] code;
      logic [7:0] center, v;
      int         r, c;
      code   = '0;
      center = win[4'((1 + int'(row_off)) * 3 + 1 + int'(col_off))];
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            r = i + int'(row_off);
            c = j + int'(col_off);
            if (r > 2 || c > 2) begin
               v = '0;
            end else begin
               v = win[4'(r * 3 + c)];
            end
            if (v < center) begin
               code[4'(8 - (3 * j + i))] = 1'b1;
            end
         end
      end
      return code;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_code   = rsp_code_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      top = cur_flags_ff.y_ge2 ? older_rd_ff : 8'd0;
      mid = cur_flags_ff.y_ge1 ? newer_rd_ff : 8'd0;
      win_in[0] = cur_flags_ff.x_first ? 8'd0 : win_ff[1];
      win_in[1] = cur_flags_ff.x_first ? 8'd0 : win_ff[2];
      win_in[2] = top;
      win_in[3] = cur_flags_ff.x_first ? 8'd0 : win_ff[4];
      win_in[4] = cur_flags_ff.x_first ? 8'd0 : win_ff[5];
      win_in[5] = mid;
      win_in[6] = cur_flags_ff.x_first ? 8'd0 : win_ff[7];
      win_in[7] = cur_flags_ff.x_first ? 8'd0 : win_ff[8];
      win_in[8] = cur_gray_ff;
      new_mask[cgct_pkg::SLOT_ABOVE_LEFT]  = cur_flags_ff.y_ge1 && !cur_flags_ff.x_first;
      new_mask[cgct_pkg::SLOT_ABOVE_RIGHT] = cur_flags_ff.y_ge1 && cur_flags_ff.x_last;
      new_mask[cgct_pkg::SLOT_LAST_LEFT]   = cur_flags_ff.y_last && !cur_flags_ff.x_first;
      new_mask[cgct_pkg::SLOT_LAST_RIGHT]  = cur_flags_ff.y_last && cur_flags_ff.x_last;
      if (pend_ff[cgct_pkg::SLOT_ABOVE_LEFT]) begin
         sel = cgct_pkg::SLOT_ABOVE_LEFT;
      end else if (pend_ff[cgct_pkg::SLOT_ABOVE_RIGHT]) begin
         sel = cgct_pkg::SLOT_ABOVE_RIGHT;
      end else if (pend_ff[cgct_pkg::SLOT_LAST_LEFT]) begin
         sel = cgct_pkg::SLOT_LAST_LEFT;
      end else begin
         sel = cgct_pkg::SLOT_LAST_RIGHT;
      end
      pend_left = pend_ff & ~(4'b0001 << sel);
   end

   // Next state.
   always_comb begin
      case (state_ff)
         cgct_pkg::BK_FETCH: begin
            state_in = queue_status.empty ? cgct_pkg::BK_FETCH : cgct_pkg::BK_UPDATE;
         end
         cgct_pkg::BK_UPDATE: begin
            state_in = (new_mask == '0) ? cgct_pkg::BK_FETCH : cgct_pkg::BK_EMIT;
         end
         cgct_pkg::BK_EMIT: begin
            state_in = (out_free && pend_left == '0) ? cgct_pkg::BK_FETCH
                                                     : cgct_pkg::BK_EMIT;
         end
         default: begin
            state_in = cgct_pkg::BK_FETCH;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      pop      = 1'b0;
      mem_wr   = 1'b0;
      win_load = 1'b0;
      emit     = 1'b0;
      pend_in  = pend_ff;
      case (state_ff)
         cgct_pkg::BK_FETCH: begin
            pop = !queue_status.empty;
         end
         cgct_pkg::BK_UPDATE: begin
            mem_wr   = 1'b1;
            win_load = 1'b1;
            pend_in  = new_mask;
         end
         cgct_pkg::BK_EMIT: begin
            emit = out_free;
            if (out_free) begin
               pend_in = pend_left;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cgct_pkg::BK_FETCH;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (win_load) begin
            win_ff <= win_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_gray_ff  <= head_gray;
         cur_x_ff     <= head_x;
         cur_flags_ff <= head_flags;
      end
      if (emit) begin
         rsp_code_ff <= census_of(win_ff, sel[1], sel[0]);
         rsp_last_ff <= (sel == cgct_pkg::SLOT_LAST_RIGHT);
      end
   end

   // Line stores: the row above moves to the older store as the new gray
   // value takes its place.
   always_ff @(posedge clock) begin
      if (pop) begin
         older_rd_ff <= older_mem[head_x];
         newer_rd_ff <= newer_mem[head_x];
      end
      if (mem_wr) begin
         older_mem[cur_x_ff] <= newer_rd_ff;
         newer_mem[cur_x_ff] <= cur_gray_ff;
      end
   end

endmodule

@@ hw/rtl/contrast_gray_census_transform_top.sv @@
// ----------------------------------------------------------------------------
// contrast_gray_census_transform_top: 3x3 census codes of a gray raster
// Contrast-adjusted gray conversion, line stores and nine-bit census codes.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the req_ stream, one three-channel word
// each; every channel is scaled by contrast_gain (unsigned, GAIN_FRAC_BITS
// fraction bits), offset by brightness_offset, rounded and clamped to 0..255,
// then the three are mixed into one gray value. Each pixel is given a 3x3
// neighborhood, zero outside the frame, and every neighbor strictly smaller
// than the center sets one bit of a nine-bit code, top-left neighbor in bit 8
// and columns running top to bottom, so the center bit is always zero. Codes
// leave on the rsp_ stream in raster order as soon as their window is
// complete; a pixel of the last row also finishes its own row, so it can send
// up to four codes, the row-above code first. rsp_tlast marks the code of the
// frame's final pixel. The front pipeline takes up to one word per cycle and
// fills a four-entry queue, stalling while that queue is full; the back
// handles one pixel at a time, reading the line stores, shifting the window
// and then sending each code the pixel completes through its single output
// register. The line stores are not cleared after reset: rows outside the
// frame are masked to zero, so no stale entry reaches a code. The user must
// see that configuration is written only while the block is idle; the block
// itself does not enforce this. The row and column counters are never reset
// by a register write, and a frame size out of range is brought into range.
// ----------------------------------------------------------------------------
module contrast_gray_census_transform_top #(
   parameter int MAX_WIDTH      = 1024,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input pixel words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan0 [7:0], chan1 [15:8], chan2 [23:16]
   // Output code words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // census_code [8:0], zero [15:9]
   output logic        rsp_tlast,   // frame_last
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int FLAG_W = $bits(cgct_pkg::flags_type);
   localparam int ENTRY_W = CW + FLAG_W + 8;

   // Configuration registers.
   logic [10:0]       frame_width_ff;
   logic [10:0]       frame_height_ff;
   logic [10:0]       contrast_gain_ff;
   logic [8:0]        brightness_offset_ff;
   cgct_pkg::cfg_type cfg;

   // Queue between the front and the back.
   logic                       q_push, q_pop;
   logic [7:0]                 push_gray, head_gray;
   logic [CW-1:0]              push_x, head_x;
   cgct_pkg::flags_type        push_flags, head_flags;
   logic [ENTRY_W-1:0]         q_push_data, q_pop_data;
   cgct_pkg::queue_status_type queue_status;

   logic [8:0] rsp_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff       <= cgct_pkg::FRAME_WIDTH_RESET;
         frame_height_ff      <= cgct_pkg::FRAME_HEIGHT_RESET;
         contrast_gain_ff     <= cgct_pkg::CONTRAST_GAIN_RESET;
         brightness_offset_ff <= cgct_pkg::BRIGHTNESS_OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cgct_pkg::CSR_FRAME_WIDTH:       frame_width_ff       <= csr_wdata;
            cgct_pkg::CSR_FRAME_HEIGHT:      frame_height_ff      <= csr_wdata;
            cgct_pkg::CSR_CONTRAST_GAIN:     contrast_gain_ff     <= csr_wdata;
            cgct_pkg::CSR_BRIGHTNESS_OFFSET: brightness_offset_ff <= csr_wdata[8:0];
            default: begin
               frame_width_ff <= frame_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      cfg.frame_width       = frame_width_ff;
      cfg.frame_height      = frame_height_ff;
      cfg.contrast_gain     = contrast_gain_ff;
      cfg.brightness_offset = $signed(brightness_offset_ff);
   end

   // The front converts and classifies each pixel ahead of the back.
   cgct_front #(
      .MAX_WIDTH      (MAX_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_status.full),
      .push       (q_push),
      .push_gray  (push_gray),
      .push_x     (push_x),
      .push_flags (push_flags)
   );

   assign q_push_data = {push_x, push_flags, push_gray};

   cgct_fifo #(
      .DATA_W (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (queue_status)
   );

   assign head_gray  = q_pop_data[7:0];
   assign head_flags = q_pop_data[FLAG_W+7:8];
   assign head_x     = q_pop_data[ENTRY_W-1:FLAG_W+8];

   // The back owns the line stores, the window and the output register.
   cgct_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (q_pop),
      .head_gray    (head_gray),
      .head_x       (head_x),
      .head_flags   (head_flags),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_code     (rsp_code),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_code};

   // The front never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && queue_status.full))
      else $error("queue pushed while full");

   // The back never pops an empty queue.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && queue_status.empty))
      else $error("queue popped while empty");

   // An empty queue stays empty until the front pushes.
   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (queue_status.empty && !q_push) |=> queue_status.empty)
      else $error("queue left empty without a push");

endmodule
